@@ rtl/mscrb_pkg.sv @@
// Package: shared types and codes for the MIPS subset core with row buffer.
package mscrb_pkg;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_BEQ  = 4'd3,
    CMD_BNE  = 4'd4,
    CMD_SLT  = 4'd5,
    CMD_J    = 4'd6,
    CMD_LW   = 4'd7,
    CMD_SW   = 4'd8,
    CMD_ADDI = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_ZERO  = 3'd1,
    ERR_HIGH  = 3'd2,
    ERR_LOW   = 3'd3,
    ERR_ALIGN = 3'd4,
    ERR_TGT   = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_OPEN = 2'd1,
    ACT_SWAP = 2'd2,
    ACT_COL  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CFG_ROW_DELAY = 2'd0,
    CFG_COL_DELAY = 2'd1,
    CFG_DATA_BASE = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_WB_RD,
    ST_WB_WR,
    ST_FETCH_RD,
    ST_FETCH_WR,
    ST_ROW_ACC,
    ST_LOAD_WR,
    ST_OUT
  } state_e;

endpackage

@@ rtl/mscrb_ram.sv @@
// Generic single-port RAM with registered read.
module mscrb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

@@ rtl/mips_subset_core_with_row_buffer_dram.sv @@
// Top level: MIPS subset executor with DRAM open-row buffer timing.
//
// Channel  Dir  Payload
// s_axis   in   cmd, reg_a, reg_b, reg_c, immediate
// m_axis   out  next_pc, step_cycles, dram_activity, error_code, totals
// cfg      in   row_delay, col_delay, data_base
//
// Register ops: three register file reads, then execute, then the result; mul
// adds a multiply state; a row hit adds a row access state, plus a load write
// state for lw. lw/sw add row-buffer work: a row fetch walks ROW_BYTES/4 words
// through the single word-memory port (a read and a write per word); a conflict
// first writes back the open row the same way. After reset a clearing pass over
// MEM_BYTES/4 words zeroes word memory and registers; s_axis_tready is low meanwhile.
// One item at a time; the result register holds until m_axis_tready.
module mips_subset_core_with_row_buffer_dram
  import mscrb_pkg::*;
#(
  parameter int MEM_BYTES  = 1048576,
  parameter int ROW_BYTES  = 1024,
  parameter int PROG_LINES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[3:0], reg_a[8:4], reg_b[13:9], reg_c[18:14], immediate[50:19], zero pad
  input  logic [55:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_pc[11:0], step_cycles[21:12], dram_activity[23:22], error_code[26:24],
  // total_cycles[66:27], row_updates[98:67], zero pad
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [20:0]  cfg_data_i
);
  localparam int MemWords = MEM_BYTES / 4;
  localparam int RowWords = ROW_BYTES / 4;
  localparam int MAw = $clog2(MemWords);
  localparam int RAw = $clog2(RowWords);
  localparam int RowAw = MAw - RAw;
  localparam int PcW = 12;

  state_e state_q, state_d;
  logic clr_q;
  logic [MAw-1:0] clr_cnt_q;

  logic [7:0]  row_delay_q, col_delay_q;
  logic [20:0] data_base_q;

  logic [3:0]  cmd_q;
  logic [4:0]  ra_q, rb_q, rc_q;
  logic [31:0] imm_q;
  logic [31:0] va_q, vb_q, vc_q;
  logic [31:0] mul_q;

  logic [PcW-1:0] pc_q;
  logic [39:0] tot_q;
  logic [31:0] upd_q;
  logic [RowAw-1:0] orow_q;
  logic        open_q;
  logic [RowAw-1:0] nrow_q;
  logic [RAw-1:0]   col_q;
  logic [RAw-1:0]   wcnt_q;

  logic [PcW-1:0] o_pc_q;
  logic [9:0]  o_cyc_q;
  logic [1:0]  o_act_q;
  logic [2:0]  o_err_q;

  // register file: read port muxed by phase
  logic        rf_we;
  logic [4:0]  rf_addr;
  logic [31:0] rf_wd, rf_rd;
  mscrb_ram #(.Width(32), .Depth(32)) u_rf (
    .clk_i, .we_i(rf_we), .addr_i(rf_addr), .wdata_i(rf_wd), .rdata_o(rf_rd));

  logic           wm_we;
  logic [MAw-1:0] wm_addr;
  logic [31:0]    wm_wd, wm_rd;
  mscrb_ram #(.Width(32), .Depth(MemWords)) u_wm (
    .clk_i, .we_i(wm_we), .addr_i(wm_addr), .wdata_i(wm_wd), .rdata_o(wm_rd));

  logic           rb_we;
  logic [RAw-1:0] rb_addr;
  logic [31:0]    rb_wd, rb_rd;
  mscrb_ram #(.Width(32), .Depth(RowWords)) u_rb (
    .clk_i, .we_i(rb_we), .addr_i(rb_addr), .wdata_i(rb_wd), .rdata_o(rb_rd));

  // read sub-phase within ST_READ: 0 -> b, 1 -> c, 2 -> a
  logic [1:0] rph_q;

  logic [4:0]  in_a, in_b, in_c;
  assign in_a = s_axis_tdata[8:4];
  assign in_b = s_axis_tdata[13:9];
  assign in_c = s_axis_tdata[18:14];

  // address and checks
  logic signed [33:0] addr;
  logic        is_mem, is_alu, is_br, taken;
  logic signed [33:0] tgt;
  logic [2:0]  err;
  logic [31:0] alu_v;
  logic [PcW-1:0] seq_pc;
  logic [RowAw-1:0] arow;
  logic [RAw-1:0]   acol;
  logic [9:0]  mem_cyc;
  logic [1:0]  mem_act;
  logic [1:0]  mem_upd;

  always_comb begin
    addr = {{2{vb_q[31]}}, vb_q} + {{2{imm_q[31]}}, imm_q};
    tgt = {{2{imm_q[31]}}, imm_q} - 34'sd1;
    is_alu = cmd_q == CMD_ADD || cmd_q == CMD_SUB || cmd_q == CMD_MUL ||
             cmd_q == CMD_SLT || cmd_q == CMD_ADDI;
    is_br = cmd_q == CMD_BEQ || cmd_q == CMD_BNE || cmd_q == CMD_J;
    is_mem = cmd_q == CMD_LW || cmd_q == CMD_SW;
    taken = (cmd_q == CMD_J) || (cmd_q == CMD_BEQ && va_q == vb_q) ||
            (cmd_q == CMD_BNE && va_q != vb_q);
    seq_pc = (32'(pc_q) + 32'd1 >= 32'(PROG_LINES)) ? '0 : pc_q + 1'b1;
    err = ERR_OK;
    if ((is_alu || cmd_q == CMD_LW) && ra_q == 5'd0) err = ERR_ZERO;
    else if (is_br && taken && (tgt < 34'sd1 || tgt >= 34'(PROG_LINES))) err = ERR_TGT;
    else if (is_mem && addr >= 34'(MEM_BYTES)) err = ERR_HIGH;
    else if (is_mem && addr < $signed({13'd0, data_base_q})) err = ERR_LOW;
    else if (is_mem && addr[1:0] != 2'b00) err = ERR_ALIGN;
    case (cmd_q)
      CMD_ADD: alu_v = vb_q + vc_q;
      CMD_SUB: alu_v = vb_q - vc_q;
      CMD_SLT: alu_v = {31'd0, $signed(vb_q) < $signed(vc_q)};
      CMD_ADDI: alu_v = vb_q + imm_q;
      default: alu_v = mul_q;
    endcase
    arow = addr[MAw+1:RAw+2];
    acol = addr[RAw+1:2];
    if (!open_q) begin
      mem_act = ACT_OPEN;
      mem_cyc = 10'd1 + 10'(row_delay_q) + 10'(col_delay_q);
    end else if (arow == orow_q) begin
      mem_act = ACT_COL;
      mem_cyc = 10'd1 + 10'(col_delay_q);
    end else begin
      mem_act = ACT_SWAP;
      mem_cyc = 10'd1 + {1'b0, row_delay_q, 1'b0} + 10'(col_delay_q);
    end
    if (mem_act == ACT_COL) mem_upd = (cmd_q == CMD_SW) ? 2'd1 : 2'd0;
    else mem_upd = (cmd_q == CMD_SW) ? 2'd2 : 2'd1;
  end

  // memory port muxing
  always_comb begin
    rf_we = 1'b0; rf_addr = rb_q; rf_wd = alu_v;
    wm_we = 1'b0; wm_addr = '0; wm_wd = rb_rd;
    rb_we = 1'b0; rb_addr = wcnt_q; rb_wd = wm_rd;
    if (clr_q) begin
      wm_we = 1'b1; wm_addr = clr_cnt_q; wm_wd = '0;
      rf_we = 1'b1; rf_addr = clr_cnt_q[4:0]; rf_wd = '0;
    end
    case (state_q)
      ST_IDLE: rf_addr = clr_q ? clr_cnt_q[4:0] : in_b;
      ST_READ: rf_addr = (rph_q == 2'd0) ? rc_q : ra_q;
      ST_EXEC: begin
        rf_addr = ra_q;
        if (is_alu && cmd_q != CMD_MUL && err == ERR_OK) rf_we = 1'b1;
      end
      ST_MUL: begin
        rf_addr = ra_q; rf_we = 1'b1; rf_wd = mul_q;
      end
      ST_WB_RD: rb_addr = wcnt_q;
      ST_WB_WR: begin
        wm_we = 1'b1; wm_addr = {orow_q, wcnt_q}; wm_wd = rb_rd;
      end
      ST_FETCH_RD: wm_addr = {nrow_q, wcnt_q};
      ST_FETCH_WR: begin
        rb_we = 1'b1; rb_addr = wcnt_q; rb_wd = wm_rd;
        wm_addr = {nrow_q, wcnt_q};
      end
      ST_ROW_ACC: begin
        rb_addr = col_q;
        if (cmd_q == CMD_SW) begin
          rb_we = 1'b1; rb_wd = va_q;
        end
      end
      ST_LOAD_WR: begin
        rf_we = 1'b1; rf_addr = ra_q; rf_wd = rb_rd;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_READ;
      ST_READ: if (rph_q == 2'd2) state_d = ST_EXEC;
      ST_EXEC: begin
        if (err != ERR_OK || !is_mem) state_d = (cmd_q == CMD_MUL && err == ERR_OK)
                                               ? ST_MUL : ST_OUT;
        else if (mem_act == ACT_COL) state_d = ST_ROW_ACC;
        else if (mem_act == ACT_SWAP) state_d = ST_WB_RD;
        else state_d = ST_FETCH_RD;
      end
      ST_MUL: state_d = ST_OUT;
      ST_WB_RD: state_d = ST_WB_WR;
      ST_WB_WR: state_d = (&wcnt_q) ? ST_FETCH_RD : ST_WB_RD;
      ST_FETCH_RD: state_d = ST_FETCH_WR;
      ST_FETCH_WR: state_d = (&wcnt_q) ? ST_ROW_ACC : ST_FETCH_RD;
      ST_ROW_ACC: state_d = (cmd_q == CMD_LW) ? ST_LOAD_WR : ST_OUT;
      ST_LOAD_WR: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !clr_q;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {5'd0, upd_q, tot_q, o_err_q, o_act_q, o_cyc_q, o_pc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
      row_delay_q <= 8'd10;
      col_delay_q <= 8'd2;
      data_base_q <= '0;
      pc_q <= '0;
      tot_q <= '0;
      upd_q <= '0;
      orow_q <= '0;
      open_q <= 1'b0;
      rph_q <= '0;
      wcnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (&clr_cnt_q) clr_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_DELAY: row_delay_q <= cfg_data_i[7:0];
          CFG_COL_DELAY: col_delay_q <= cfg_data_i[7:0];
          CFG_DATA_BASE: data_base_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_READ) rph_q <= (rph_q == 2'd2) ? 2'd0 : rph_q + 1'b1;
      if (state_q == ST_EXEC) begin
        wcnt_q <= '0;
        if (err == ERR_OK) begin
          pc_q <= (is_br && taken) ? tgt[PcW-1:0] : seq_pc;
          tot_q <= tot_q + 40'(is_mem ? mem_cyc : 10'd1);
          if (is_mem) begin
            upd_q <= upd_q + 32'(mem_upd);
            open_q <= 1'b1;
          end
        end
      end
      // open row index moves only after the write-back of the old row
      if (state_q == ST_ROW_ACC) orow_q <= nrow_q;
      if (state_q == ST_WB_WR || state_q == ST_FETCH_WR) wcnt_q <= wcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[3:0];
      ra_q <= in_a; rb_q <= in_b; rc_q <= in_c;
      imm_q <= s_axis_tdata[50:19];
    end
    if (state_q == ST_READ) begin
      case (rph_q)
        2'd0: vb_q <= rf_rd;
        2'd1: vc_q <= rf_rd;
        default: va_q <= rf_rd;
      endcase
    end
    if (state_q == ST_READ && rph_q == 2'd2) mul_q <= vb_q * vc_q;
    if (state_q == ST_EXEC) begin
      nrow_q <= arow;
      col_q <= acol;
      o_pc_q <= (err != ERR_OK) ? pc_q : ((is_br && taken) ? tgt[PcW-1:0] : seq_pc);
      o_err_q <= err;
      o_cyc_q <= (err == ERR_OK && is_mem) ? mem_cyc : 10'd1;
      o_act_q <= (err == ERR_OK && is_mem) ? mem_act : ACT_NONE;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready) else $error("accept during clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_act_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_err_q != ERR_OK) |-> (o_act_q == ACT_NONE && o_cyc_q == 10'd1))
    else $error("error with activity");
  a_open_after_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_ACC) |-> open_q) else $error("row access with no open row");
`endif
endmodule

@@ test/mips_subset_core_with_row_buffer_dram_test.sv @@
// Testbench: MIPS subset core with DRAM row buffer, checked against a predictor.
`timescale 1ns / 1ps

module mips_subset_core_with_row_buffer_dram_test;
  import mscrb_pkg::*;

  localparam int  MEM_WORDS  = 262144;
  localparam int  ROW_WORDS  = 256;
  localparam int  PROG_LINES = 4096;
  localparam longint LIMIT   = 10_000_000;

  typedef struct packed {
    logic [31:0] imm;
    logic [4:0]  rc;
    logic [4:0]  rb;
    logic [4:0]  ra;
    logic [3:0]  cmd;
  } instr_t;

  typedef struct packed {
    logic [31:0] upd;
    logic [39:0] tot;
    logic [2:0]  err;
    logic [1:0]  act;
    logic [9:0]  cyc;
    logic [11:0] pc;
  } retire_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = CFG_ROW_DELAY;
  logic [20:0]  cfg_data_i = '0;

  mips_subset_core_with_row_buffer_dram DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] dram [MEM_WORDS];
  logic [31:0] row_buf [ROW_WORDS];
  logic [9:0]  row_idx;
  logic        row_open;
  logic [11:0] pc_q;
  logic [39:0] cyc_total;
  logic [31:0] upd_total;
  logic [7:0]  row_delay;
  logic [7:0]  col_delay;
  logic [20:0] data_base;

  instr_t  instr_q [$];
  retire_t retire_q [$];
  instr_t  cur_instr;
  int      idle_mode;
  int      fail_cnt, instr_cnt, retire_cnt, mem_cnt;
  int      gen_row;
  longint  cycle_cnt;
  bit      taken;

  function automatic retire_t execute(instr_t it);
    retire_t r;
    logic [31:0] rb, rc, v;
    logic [11:0] nxt;
    longint addr, tgt;
    int row, col, i;
    bit br;
    rb = gpr[it.rb];
    rc = gpr[it.rc];
    nxt = (pc_q == PROG_LINES - 1) ? 12'd0 : pc_q + 12'd1;
    r = '0;
    r.cyc = 10'd1;
    r.act = ACT_NONE;
    r.err = ERR_OK;
    case (it.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_SLT, CMD_ADDI: begin
        if (it.ra == 0) begin
          r.err = ERR_ZERO;
        end else begin
          case (it.cmd)
            CMD_ADD: v = rb + rc;
            CMD_SUB: v = rb - rc;
            CMD_MUL: v = rb * rc;
            CMD_SLT: v = ($signed(rb) < $signed(rc)) ? 32'd1 : 32'd0;
            default: v = rb + it.imm;
          endcase
          gpr[it.ra] = v;
        end
      end
      CMD_BEQ, CMD_BNE, CMD_J: begin
        br = (it.cmd == CMD_J) || (it.cmd == CMD_BEQ && gpr[it.ra] == rb) ||
             (it.cmd == CMD_BNE && gpr[it.ra] != rb);
        if (br) begin
          tgt = longint'($signed(it.imm)) - 1;
          if (tgt < 1 || tgt >= PROG_LINES) r.err = ERR_TGT;
          else nxt = tgt[11:0];
        end
      end
      CMD_LW, CMD_SW: begin
        addr = longint'($signed(rb)) + longint'($signed(it.imm));
        if (it.cmd == CMD_LW && it.ra == 0) r.err = ERR_ZERO;
        else if (addr >= MEM_WORDS * 4) r.err = ERR_HIGH;
        else if (addr < longint'(data_base)) r.err = ERR_LOW;
        else if (addr[1:0] != 2'b00) r.err = ERR_ALIGN;
        else begin
          row = int'(addr / 1024);
          col = int'((addr % 1024) / 4);
          if (row_open && row == row_idx) begin
            r.act = ACT_COL;
            r.cyc = 10'd1 + col_delay;
          end else begin
            if (row_open) begin
              for (i = 0; i < ROW_WORDS; i++) dram[row_idx * ROW_WORDS + i] = row_buf[i];
              r.act = ACT_SWAP;
              r.cyc = 10'd1 + 10'd2 * row_delay + col_delay;
            end else begin
              r.act = ACT_OPEN;
              r.cyc = 10'd1 + row_delay + col_delay;
            end
            for (i = 0; i < ROW_WORDS; i++) row_buf[i] = dram[row * ROW_WORDS + i];
          end
          if (it.cmd == CMD_LW) upd_total += (r.act == ACT_COL) ? 0 : 1;
          else upd_total += (r.act == ACT_COL) ? 1 : 2;
          row_idx = row[9:0];
          row_open = 1'b1;
          if (it.cmd == CMD_LW) gpr[it.ra] = row_buf[col];
          else row_buf[col] = gpr[it.ra];
        end
      end
      default: ;
    endcase
    if (r.err != ERR_OK) begin
      nxt = pc_q;
      r.cyc = 10'd1;
      r.act = ACT_NONE;
    end else begin
      pc_q = nxt;
      cyc_total = cyc_total + r.cyc;
    end
    r.pc = nxt;
    r.tot = cyc_total;
    r.upd = upd_total;
    return r;
  endfunction

  function automatic instr_t mk(logic [3:0] cmd, int ra, int rb, int rc, logic [31:0] imm);
    instr_t it;
    it.cmd = cmd;
    it.ra = ra[4:0];
    it.rb = rb[4:0];
    it.rc = rc[4:0];
    it.imm = imm;
    return it;
  endfunction

  task automatic queue_instr(instr_t it);
    instr_q.insert(instr_q.size(), it);
  endtask

  // mostly valid programs with random content, a share of broken accesses and noise
  function automatic instr_t rand_instr();
    instr_t it;
    int sel, lo_word, w;
    it = mk(CMD_ADD, $urandom_range(31), $urandom_range(31), $urandom_range(31), $urandom);
    if ($urandom_range(99) < 4) it.ra = 5'd0;
    sel = $urandom_range(99);
    if (sel < 12) it.cmd = CMD_ADDI;
    else if (sel < 30) it.cmd = 4'($urandom_range(2)) == 2 ? CMD_SLT : 4'($urandom_range(2));
    else if (sel < 40) begin
      it.cmd = $urandom_range(1) ? CMD_BEQ : CMD_BNE;
      if ($urandom_range(9) != 0) it.imm = $urandom_range(PROG_LINES, 2);
    end else if (sel < 45) begin
      it.cmd = CMD_J;
      if ($urandom_range(4) != 0) it.imm = $urandom_range(PROG_LINES, 2);
    end else if (sel < 93) begin
      it.cmd = $urandom_range(1) ? CMD_LW : CMD_SW;
      lo_word = (data_base + 3) / 4;
      if ($urandom_range(9) != 0 && lo_word < MEM_WORDS) begin
        if ($urandom_range(99) < 12 || gen_row * ROW_WORDS + ROW_WORDS <= lo_word)
          gen_row = $urandom_range(MEM_WORDS - 1, lo_word) / ROW_WORDS;
        w = gen_row * ROW_WORDS + $urandom_range(ROW_WORDS - 1);
        if (w < lo_word) w = lo_word;
        it.rb = 5'd0;
        it.imm = w * 4;
        if ($urandom_range(19) == 0) it.imm[1:0] = 2'($urandom_range(3, 1));
      end else if ($urandom_range(1)) begin
        it.rb = 5'd0;
        it.imm = $urandom_range(MEM_WORDS * 8, MEM_WORDS * 4 - 8);
      end
    end else begin
      it.cmd = 4'($urandom_range(15, 10));
    end
    return it;
  endfunction

  // driver
  always @(posedge clk_i) begin
    taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      retire_q.insert(retire_q.size(), execute(cur_instr));
      instr_cnt++;
      if (cur_instr.cmd == CMD_LW || cur_instr.cmd == CMD_SW) mem_cnt++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || taken)) begin
      if (instr_q.size() > 0 &&
          !((idle_mode == 1 && $urandom_range(99) < 69) ||
            (idle_mode == 3 && $urandom_range(99) < 33))) begin
        cur_instr = instr_q.pop_front();
        s_axis_tdata <= {5'd0, cur_instr};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !((idle_mode == 2 && $urandom_range(99) < 69) ||
                       (idle_mode == 3 && $urandom_range(99) < 33));
  end

  // monitor
  always @(posedge clk_i) begin
    retire_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[98:0];
      retire_cnt++;
      if (retire_q.size() == 0) begin
        $error("unexpected transfer: %h", got);
        fail_cnt++;
      end else begin
        exp_r = retire_q.pop_front();
        if (got.pc !== exp_r.pc) begin
          $error("next_pc exp %0d got %0d", exp_r.pc, got.pc); fail_cnt++;
        end
        if (got.cyc !== exp_r.cyc) begin
          $error("step_cycles exp %0d got %0d", exp_r.cyc, got.cyc); fail_cnt++;
        end
        if (got.act !== exp_r.act) begin
          $error("dram_activity exp %0d got %0d", exp_r.act, got.act); fail_cnt++;
        end
        if (got.err !== exp_r.err) begin
          $error("error_code exp %0d got %0d", exp_r.err, got.err); fail_cnt++;
        end
        if (got.tot !== exp_r.tot) begin
          $error("total_cycles exp %0d got %0d", exp_r.tot, got.tot); fail_cnt++;
        end
        if (got.upd !== exp_r.upd) begin
          $error("row_updates exp %0d got %0d", exp_r.upd, got.upd); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout with %0d transfers outstanding", retire_q.size());
      $display("** mips_subset_core_with_row_buffer_dram: FAILED **");
      $finish;
    end
  end

  task automatic set_reg(cfg_e idx, logic [20:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROW_DELAY: row_delay = val[7:0];
      CFG_COL_DELAY: col_delay = val[7:0];
      default:       data_base = val;
    endcase
  endtask

  task automatic drain();
    wait (instr_q.size() == 0 && !s_axis_tvalid && retire_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    int p, n;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dram[i]) dram[i] = '0;
    foreach (row_buf[i]) row_buf[i] = '0;
    row_idx = '0; row_open = 1'b0; pc_q = '0; cyc_total = '0; upd_total = '0;
    row_delay = 8'd10; col_delay = 8'd2; data_base = '0;
    idle_mode = 0; gen_row = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    queue_instr(mk(CMD_ADDI, 1, 0, 0, 32'h7fff_ffff));
    queue_instr(mk(CMD_ADDI, 2, 0, 0, 32'h8000_0000));
    queue_instr(mk(CMD_ADD, 3, 1, 1, 0));
    queue_instr(mk(CMD_SUB, 4, 2, 1, 0));
    queue_instr(mk(CMD_MUL, 5, 1, 2, 0));
    queue_instr(mk(CMD_SLT, 6, 2, 1, 0));
    queue_instr(mk(CMD_SLT, 31, 31, 31, 0));
    queue_instr(mk(CMD_ADDI, 0, 1, 0, 5));
    queue_instr(mk(CMD_MUL, 0, 1, 1, 0));
    queue_instr(mk(CMD_LW, 7, 0, 0, 32'd4096));
    queue_instr(mk(CMD_SW, 1, 0, 0, 32'd4100));
    queue_instr(mk(CMD_LW, 8, 0, 0, 32'd4100));
    queue_instr(mk(CMD_SW, 2, 0, 0, 32'd1048572));
    queue_instr(mk(CMD_LW, 9, 0, 0, 32'd4100));
    queue_instr(mk(CMD_LW, 0, 0, 0, 32'd0));
    queue_instr(mk(CMD_SW, 1, 0, 0, 32'd1048576));
    queue_instr(mk(CMD_SW, 1, 0, 0, 32'd6));
    queue_instr(mk(CMD_LW, 10, 1, 0, 32'h8000_0001));
    queue_instr(mk(CMD_BEQ, 0, 0, 0, 32'd4096));
    queue_instr(mk(CMD_BNE, 1, 2, 0, 32'd3));
    queue_instr(mk(CMD_J, 0, 0, 0, 32'd1));
    queue_instr(mk(CMD_J, 0, 0, 0, 32'd4097));
    queue_instr(mk(CMD_J, 0, 0, 0, 32'hffff_ffff));
    queue_instr(mk(4'd15, 31, 31, 31, 0));

    for (p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: begin
            set_reg(CFG_ROW_DELAY, 21'd1); set_reg(CFG_COL_DELAY, 21'd1);
            set_reg(CFG_DATA_BASE, 21'd0);
          end
          2: begin
            set_reg(CFG_ROW_DELAY, 21'd255); set_reg(CFG_COL_DELAY, 21'd255);
            set_reg(CFG_DATA_BASE, 21'd524290);
          end
          3: set_reg(CFG_DATA_BASE, 21'd1048576);
          default: begin
            set_reg(CFG_ROW_DELAY, 21'($urandom_range(255, 1)));
            set_reg(CFG_COL_DELAY, 21'($urandom_range(255, 1)));
            set_reg(CFG_DATA_BASE, 21'($urandom_range(1048576)));
          end
        endcase
      end
      idle_mode = p % 4;
      n = (p == 3) ? 100 : 280;
      repeat (n) queue_instr(rand_instr());
    end
    drain();
    repeat (100) @(posedge clk_i);
    $display("ran %0d instructions (%0d loads/stores), %0d results checked, six settings",
             instr_cnt, mem_cnt, retire_cnt);
    if (fail_cnt == 0 && retire_q.size() == 0) begin
      $display("** mips_subset_core_with_row_buffer_dram: PASSED **");
    end else begin
      $display("** mips_subset_core_with_row_buffer_dram: FAILED **");
    end
    $finish;
  end

endmodule

@@ mips_subset_core_with_row_buffer_dram.f @@
rtl/mscrb_pkg.sv
rtl/mscrb_ram.sv
rtl/mips_subset_core_with_row_buffer_dram.sv
test/mips_subset_core_with_row_buffer_dram_test.sv
